/* hw/rtl/gjpc_pkg.sv */
`timescale 1ns / 1ps

package gjpc_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;

    localparam int SIZE_W   = 9;    // grid_rows / grid_cols register width
    localparam int JUMP_W   = 8;
    localparam int CNT_W    = 30;

    localparam logic [CNT_W-1:0] PATH_MOD = CNT_W'(1000000007);

    // register indexes on the config port
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SIZE_W-1:0] size_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        cnt_t  data;
    } wr_req_t;

    // per-item sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DOWN,
        PH_RIGHT,
        PH_CLEAR
    } phase_t;

    function automatic cnt_t mod_add(input cnt_t a, input cnt_t b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PATH_MOD})
        begin
            s = s - {1'b0, PATH_MOD};
        end
        return s[CNT_W-1:0];
    endfunction

    // zero is used as one, anything above max as max
    function automatic size_t clamp_size(input size_t v, input int unsigned max_v);
        size_t r;
        if (v == '0)
        begin
            r = size_t'(1);
        end
        else if (32'(v) > max_v)
        begin
            r = size_t'(max_v);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/gjpc_ram.sv */
`timescale 1ns / 1ps

module gjpc_ram #(
    parameter int DATA_W = 30,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [DATA_W-1:0] rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* hw/rtl/gjpc_sweep.sv */
`timescale 1ns / 1ps

module gjpc_sweep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             restart,
    output logic             busy,
    output gjpc_pkg::wr_req_t wr_req
);
    import gjpc_pkg::*;

    logic  busy_reg, busy_next;
    addr_t addr_reg, addr_next;

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (restart)
        begin
            busy_next = 1'b1;
            addr_next = '0;
        end
        else if (busy_reg)
        begin
            addr_next = addr_reg + addr_t'(1);
            if (addr_reg == addr_t'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign busy        = busy_reg;
    assign wr_req.en   = busy_reg;
    assign wr_req.addr = addr_reg;
    assign wr_req.data = '0;

endmodule

/* hw/rtl/gjpc_seq.sv */
`timescale 1ns / 1ps

module gjpc_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      restart,
    input  logic                      sweep_busy,
    input  gjpc_pkg::size_t           rows,
    input  gjpc_pkg::size_t           cols,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [gjpc_pkg::JUMP_W-1:0] jump,
    output logic                      out_valid,
    input  logic                      out_stall,
    output gjpc_pkg::cnt_t            path_count,
    output gjpc_pkg::addr_t           rd_addr_a,
    output gjpc_pkg::addr_t           rd_addr_b,
    input  gjpc_pkg::cnt_t            rd_data_a,
    input  gjpc_pkg::cnt_t            rd_data_b,
    output gjpc_pkg::wr_req_t         wr_req
);
    import gjpc_pkg::*;

    phase_t            ph_reg, ph_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [JUMP_W-1:0] k_reg, k_next;
    logic              origin_reg, origin_next;
    logic              last_reg, last_next;
    cnt_t              own_reg, own_next;
    logic              out_valid_reg, out_valid_next;
    cnt_t              path_count_reg, path_count_next;

    logic              is_last;
    logic              accept;
    logic [SIZE_W-1:0] down_sum, right_sum, in_down_sum;
    logic              down_ok, right_ok;
    cnt_t              own_now;
    addr_t             own_addr, down_addr, right_addr;

    assign is_last = (SIZE_W'(row_reg) + SIZE_W'(1) == rows)
                  && (SIZE_W'(col_reg) + SIZE_W'(1) == cols);

    // a last cell also waits while the output slot is held
    assign in_stall = sweep_busy || (ph_reg == PH_DOWN) || (ph_reg == PH_RIGHT)
                   || (is_last && out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign in_down_sum = SIZE_W'(row_reg) + SIZE_W'(jump);
    assign down_sum    = SIZE_W'(cur_row_reg) + SIZE_W'(k_reg);
    assign right_sum   = SIZE_W'(cur_col_reg) + SIZE_W'(k_reg);
    assign down_ok     = (k_reg != '0) && (down_sum < rows);
    assign right_ok    = (k_reg != '0) && (right_sum < cols);

    assign own_addr   = {cur_row_reg, cur_col_reg};
    assign down_addr  = {down_sum[ROW_W-1:0], cur_col_reg};
    assign right_addr = {cur_row_reg, right_sum[COL_W-1:0]};

    // origin never receives a transfer, its count is one
    assign own_now = origin_reg ? cnt_t'(1) : rd_data_a;

    // port a: own count at accept, right target in the down phase
    assign rd_addr_a = (ph_reg == PH_DOWN) ? right_addr : {row_reg, col_reg};
    assign rd_addr_b = {in_down_sum[ROW_W-1:0], col_reg};

    always_comb
    begin
        ph_next         = ph_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        k_next          = k_reg;
        origin_next     = origin_reg;
        last_next       = last_reg;
        own_next        = own_reg;
        out_valid_next  = out_valid_reg && out_stall;
        path_count_next = path_count_reg;
        wr_req.en       = 1'b0;
        wr_req.addr     = own_addr;
        wr_req.data     = '0;

        unique case (ph_reg)
            PH_IDLE:
            begin
                ph_next = PH_IDLE;
            end
            PH_DOWN:
            begin
                wr_req.en   = down_ok;
                wr_req.addr = down_addr;
                wr_req.data = mod_add(rd_data_b, own_now);
                own_next    = own_now;
                if (last_reg)
                begin
                    out_valid_next  = 1'b1;
                    path_count_next = own_now;
                end
                ph_next = PH_RIGHT;
            end
            PH_RIGHT:
            begin
                wr_req.en   = right_ok;
                wr_req.addr = right_addr;
                wr_req.data = mod_add(rd_data_a, own_reg);
                ph_next     = PH_CLEAR;
            end
            PH_CLEAR:
            begin
                // leave the entry zero for the next grid
                wr_req.en   = 1'b1;
                wr_req.addr = own_addr;
                wr_req.data = '0;
                ph_next     = PH_IDLE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase

        if (accept)
        begin
            ph_next      = PH_DOWN;
            cur_row_next = row_reg;
            cur_col_next = col_reg;
            k_next       = jump;
            origin_next  = (row_reg == '0) && (col_reg == '0);
            last_next    = is_last;
            if (is_last)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (SIZE_W'(col_reg) + SIZE_W'(1) < cols)
            begin
                col_next = col_reg + COL_W'(1);
            end
            else
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
        end

        if (restart)
        begin
            ph_next  = PH_IDLE;
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ph_reg        <= ph_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg    <= cur_row_next;
        cur_col_reg    <= cur_col_next;
        k_reg          <= k_next;
        origin_reg     <= origin_next;
        last_reg       <= last_next;
        own_reg        <= own_next;
        path_count_reg <= path_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign path_count = path_count_reg;

endmodule

/* hw/rtl/grid_jump_path_count_top.sv */
`timescale 1ns / 1ps

// Grid jump path counter. Jump values of a grid_rows x grid_cols grid are fed
// one per transfer in row-major order; after the last cell one transfer on the
// output carries the number of monotone paths from the top-left to the
// bottom-right cell, modulo 1000000007, and the next grid begins. The count
// memory has a single write port, and every cell writes it up to three times
// (the cell k rows down, the cell k columns right, and clearing its own entry
// for the next grid). A new cell is taken while the previous result still
// waits on the output; only the last cell of a grid is held off while an
// earlier result is stalled. After reset and after every register write the
// block runs a clearing pass over the count memory, during which no cell is
// taken. Writing either size register also drops a grid in progress. Sizes
// of zero act as 1, above 256 act as 256.

module grid_jump_path_count_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [gjpc_pkg::SIZE_W-1:0] wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [gjpc_pkg::JUMP_W-1:0] jump,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gjpc_pkg::CNT_W-1:0]  path_count
);
    import gjpc_pkg::*;

    // size registers, held clamped
    size_t   rows_reg, rows_next;
    size_t   cols_reg, cols_next;

    logic    sweep_busy;
    wr_req_t sweep_wr;
    wr_req_t seq_wr;
    wr_req_t ram_wr;
    addr_t   rd_addr_a, rd_addr_b;
    cnt_t    rd_data_a, rd_data_b;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ROWS: rows_next = clamp_size(wr_data, MAX_ROWS);
                REG_COLS: cols_next = clamp_size(wr_data, MAX_COLS);
                default:  rows_next = rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= size_t'(1);
            cols_reg <= size_t'(1);
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    // clearing pass after reset and on each register write
    gjpc_sweep u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (wr_en),
        .busy    (sweep_busy),
        .wr_req  (sweep_wr)
    );

    // per-cell sequencer: read own and down target, then read-modify-write
    gjpc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (wr_en),
        .sweep_busy (sweep_busy),
        .rows       (rows_reg),
        .cols       (cols_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .jump       (jump),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .path_count (path_count),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .wr_req     (seq_wr)
    );

    // sweep owns the write port while it runs
    assign ram_wr = sweep_busy ? sweep_wr : seq_wr;

    gjpc_ram #(
        .DATA_W (CNT_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (ram_wr.en),
        .wr_addr   (ram_wr.addr),
        .wr_data   (ram_wr.data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

// Testbench for grid_jump_path_count_top.
// Jump values stream in row-major order. A scoreboard class keeps its own
// count memory for the grid and predicts the bottom-right path count for every
// completed grid. Each output transfer is compared with the oldest prediction.
// The sender works in random bursts and the receiver stalls on its own random
// pattern. One long output hold backs the block up onto its input.
module tb;

    import gjpc_pkg::*;

    // Allows for 7 clearing passes plus stalls, with a wide margin.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned LONG_HOLD   = 400;

    // Scoreboard: mirrors the count memory and the position of the next cell.
    class path_count_board;
        int unsigned rows;
        int unsigned cols;
        int unsigned row_at;
        int unsigned col_at;
        cnt_t        cell_count[int unsigned];   // absent entry reads as zero
        cnt_t        pending_counts[$];
        int unsigned n_cells;
        int unsigned n_checked;
        int unsigned n_errors;

        function new();
            rows = 1;
            cols = 1;
            n_cells = 0;
            n_checked = 0;
            n_errors = 0;
            start_grid();
        endfunction

        function void start_grid();
            cell_count.delete();
            cell_count[0] = 1;
            row_at = 0;
            col_at = 0;
        endfunction

        // Zero acts as one. Sizes above the maximum act as the maximum.
        function void set_size(logic idx, size_t v);
            int unsigned lim;
            int unsigned n;
            lim = (idx == REG_ROWS) ? MAX_ROWS : MAX_COLS;
            n = (v == '0) ? 1 : ((v > lim) ? lim : v);
            if (idx == REG_ROWS)
            begin
                rows = n;
            end
            else
            begin
                cols = n;
            end
            start_grid();   // a write also drops the grid in progress
        endfunction

        function void add_into(int unsigned r, int unsigned c, cnt_t v);
            logic [CNT_W:0] s;
            int unsigned    key;
            key = r * MAX_COLS + c;
            s = {1'b0, v};
            if (cell_count.exists(key))
            begin
                s = s + {1'b0, cell_count[key]};
            end
            if (s >= {1'b0, PATH_MOD})
            begin
                s = s - {1'b0, PATH_MOD};
            end
            cell_count[key] = s[CNT_W-1:0];
        endfunction

        // Input transfer accepted: the cell count is final, so push it forward.
        function void note_cell(logic [JUMP_W-1:0] k);
            cnt_t        own;
            int unsigned key;
            key = row_at * MAX_COLS + col_at;
            own = cell_count.exists(key) ? cell_count[key] : '0;
            if (k != 0)
            begin
                if (row_at + k < rows)
                begin
                    add_into(row_at + k, col_at, own);
                end
                if (col_at + k < cols)
                begin
                    add_into(row_at, col_at + k, own);
                end
            end
            n_cells++;
            if (row_at + 1 == rows && col_at + 1 == cols)
            begin
                pending_counts = {pending_counts, own};
                start_grid();
            end
            else if (col_at + 1 < cols)
            begin
                col_at++;
            end
            else
            begin
                col_at = 0;
                row_at++;
            end
        endfunction

        function void check_count(cnt_t got);
            cnt_t want;
            if (pending_counts.size() == 0)
            begin
                n_errors++;
                $display("%0t ns: path_count %0d with no grid pending", $time, got);
                return;
            end
            want = pending_counts.pop_front();
            n_checked++;
            if (got !== want)
            begin
                n_errors++;
                $display("%0t ns: path_count expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              wr_en;
    logic              wr_index;
    logic [SIZE_W-1:0] wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [JUMP_W-1:0] jump;
    logic              out_valid;
    logic              out_stall;
    logic [CNT_W-1:0]  path_count;

    path_count_board counts = new();

    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 0;
    bit          gaps_on      = 1'b1;
    int unsigned n_settings   = 1;
    // receiver state
    int unsigned hold_left    = 0;
    bit          held_once    = 1'b0;
    int unsigned mode_left    = 0;
    int unsigned stall_pct    = 0;

    grid_jump_path_count_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .jump       (jump),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .path_count (path_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Watchdog: ends the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t ns: watchdog expired after %0d cycles", $time, cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Output monitor. Values are sampled before this edge's updates.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            counts.check_count(path_count);
        end
    end

    // Receiver. It stalls at a random rate, drawn anew for each stretch of random
    // length, and the rate is sometimes zero. It holds off once for a long stretch
    // early on, while the 1x1 grids produce a result for every cell.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!held_once && counts.n_checked >= 12)
        begin
            held_once <= 1'b1;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left <= $urandom_range(60, 5);
                case ($urandom_range(4))
                    0, 1:    stall_pct <= 0;
                    2:       stall_pct <= 25;
                    3:       stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Mostly jumps from 1 up to span. Some are zero and some
    // are drawn from the full range.
    function automatic logic [JUMP_W-1:0] pick_jump(int unsigned span);
        int unsigned x;
        x = $urandom_range(99);
        if (x < 5)
        begin
            return '0;
        end
        else if (x < 15)
        begin
            return JUMP_W'($urandom_range(255));
        end
        return JUMP_W'($urandom_range(span, 1));
    endfunction

    // One input transfer. A random gap comes before each new burst. Valid
    // stays high across back-to-back transfers.
    task automatic offer_cell(input logic [JUMP_W-1:0] k);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = gaps_on ? $urandom_range(6) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        jump     <= k;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        counts.note_cell(k);
    endtask

    // Whole grids at the current size. An optional tail of cells leaves a
    // partial grid, which the next size write drops.
    task automatic run_grids(input int unsigned n_grids, input int unsigned span,
                             input int unsigned extra);
        repeat (n_grids * counts.rows * counts.cols + extra)
        begin
            offer_cell(pick_jump(span));
        end
    endtask

    // Stop offering until every predicted count has come out. Then wait, with
    // margin, for any cell still in flight to finish.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (counts.pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    // Write both size registers in back-to-back cycles. The block clears its
    // count memory afterwards and holds input stalled until the clear is done.
    task automatic set_grid(input size_t r, input size_t c);
        wr_en    <= 1'b1;
        wr_index <= REG_ROWS;
        wr_data  <= r;
        @(posedge clk);
        counts.set_size(REG_ROWS, r);
        wr_index <= REG_COLS;
        wr_data  <= c;
        @(posedge clk);
        counts.set_size(REG_COLS, c);
        wr_en <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        // 3x3 grids: all ones gives 6 paths. The second grid has zero jumps, a
        // jump of 255 and jumps that leave the grid, which leaves 2 paths.
        logic [JUMP_W-1:0] ones_grid [9];
        logic [JUMP_W-1:0] mixed_grid[9];
        logic [JUMP_W-1:0] edge_jumps[5];
        ones_grid  = '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1};
        mixed_grid = '{8'd2, 8'd0, 8'd2, 8'd255, 8'd0, 8'd0, 8'd2, 8'd0, 8'd1};
        edge_jumps = '{8'h01, 8'hFF, 8'h00, 8'h80, 8'h7F};

        rst_n     = 1'b0;
        wr_en     = 1'b0;
        wr_index  = REG_ROWS;
        wr_data   = '0;
        in_valid  = 1'b0;
        jump      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size is 1x1. Every cell is a whole grid, so every count is 1.
        foreach (edge_jumps[i])
        begin
            offer_cell(edge_jumps[i]);
        end
        run_grids(15, 255, 0);      // long output hold lands in here
        wait_drained();

        set_grid(9'd3, 9'd3);
        foreach (ones_grid[i])
        begin
            offer_cell(ones_grid[i]);
        end
        foreach (mixed_grid[i])
        begin
            offer_cell(mixed_grid[i]);
        end
        run_grids(1, 3, 0);
        wait_drained();             // sender pauses mid-setting
        run_grids(1, 3, 4);
        wait_drained();

        // Size extremes: zero acts as 1, values above 256 act as 256. The
        // 256x1 grid only gets a partial run, which the next write drops.
        set_grid(9'd0, 9'd300);
        run_grids(1, 40, 3);
        wait_drained();
        set_grid(9'd511, 9'd0);
        run_grids(0, 40, 20);
        wait_drained();

        // 17x18 with unit jumps: 1166803110 paths, so the count wraps the modulus.
        gaps_on = 1'b0;
        set_grid(9'd17, 9'd18);
        repeat (counts.rows * counts.cols)
        begin
            offer_cell(8'd1);
        end
        wait_drained();
        gaps_on = 1'b1;

        repeat (2)
        begin
            set_grid(size_t'($urandom_range(5, 2)), size_t'($urandom_range(5, 2)));
            run_grids(1, 4, $urandom_range(3));
            wait_drained();
        end

        $display("tb: %0d cells sent, %0d grid counts checked over %0d size settings",
                 counts.n_cells, counts.n_checked, n_settings);
        if (counts.n_errors == 0 && counts.pending_counts.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: %0d mismatches", counts.n_errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
